>>> src/assert_macros.svh
// Assertion macros for the checker file sptr_checker.sv.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPTR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sptr assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SPTR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sptr assertion failed");

`endif

>>> src/sptr_pkg.sv
// Package for the SOM palette trainer: widths, shift constants, FSM and
// command types, and the colour pull function. No dependencies.
`timescale 1ns / 1ps
package sptr_pkg;

    localparam int NETBIASSHIFT    = 4;
    localparam int INTBIASSHIFT    = 16;
    localparam int GAMMASHIFT      = 10;
    localparam int BETASHIFT       = 10;
    localparam int RADIUSBIASSHIFT = 6;
    localparam int RADIUSDEC       = 30;
    localparam int ALPHABIASSHIFT  = 10;
    localparam int RADBIASSHIFT    = 8;
    localparam int RPOW_DEPTH      = 32;

    localparam int COL_W     = 12;
    localparam int BIAS_W    = 32;
    localparam int FREQ_W    = 17;
    localparam int RPOW_W    = 19;
    localparam int LR_W      = 11;
    localparam int RADS_W    = 12;
    localparam int SAMP_W    = 24;
    localparam int RAD_W     = 6;
    localparam int DIST_W    = 14;
    localparam int BD_W      = 22;
    localparam int DIV_NUM_W = 19;
    localparam int DIV_DEN_W = 11;
    localparam int PROD_W    = RPOW_W + COL_W + 2;

    // Radius decay x/RADIUSDEC as (x*RAD_RECIP) >> RAD_RECIP_SH, exact for x < 4681
    localparam logic [RADS_W-1:0] RAD_RECIP    = 12'd2185;
    localparam int                RAD_RECIP_SH = 16;

    // Configuration register indexes
    localparam logic CFG_ALPHA_DIV = 1'b0;
    localparam logic CFG_DECAY_INT = 1'b1;

    localparam logic signed [PROD_W-1:0] RND_WIN =
        PROD_W'((1 << ALPHABIASSHIFT) - 1);
    localparam logic signed [PROD_W-1:0] RND_NB =
        PROD_W'((1 << (ALPHABIASSHIFT + RADBIASSHIFT)) - 1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_FILL_DIV, ST_FILL_WAIT, ST_IDLE, ST_RD, ST_RD_OUT,
        ST_SCAN, ST_SCAN_END, ST_BOOST_RD, ST_BOOST_WR, ST_WIN_RD, ST_WIN_WR,
        ST_NB_UP, ST_NB_UPW, ST_NB_DN, ST_NB_DNW, ST_DECAY, ST_LR_WAIT,
        ST_RAD_UPD, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        ADDR_IDX, ADDR_REQ, ADDR_BEST, ADDR_BESTB, ADDR_UP, ADDR_DN
    } addr_sel_t;

    typedef enum logic [1:0] {
        DIV_FILL, DIV_LR
    } div_sel_t;

    typedef struct packed {
        logic      req_load;
        logic      res_load;
        logic      clr_step;
        logic      idx_clear;
        logic      idx_inc;
        logic      mem_rd;
        addr_sel_t addr_sel;
        logic      scan_rd;
        logic      boost_wr;
        logic      move_wr;
        logic      move_nb;
        logic      m_clear;
        logic      m_inc;
        logic      k_clear;
        logic      k_inc;
        logic      fill_wr;
        logic      div_start;
        div_sel_t  div_sel;
        logic      lr_upd;
        logic      rad_upd;
        logic      samp_upd;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic div_done;
        logic rad_zero;
        logic k_last;
        logic nb_end;
        logic up_ok;
        logic dn_ok;
        logic decay_due;
        logic out_free;
    } sts_t;

    // v - factor*(v - tgt)/2^shift, division truncating toward zero, mod 4096
    function automatic logic [COL_W-1:0] pull_colour(
        input logic [COL_W-1:0]  v,
        input logic [COL_W-1:0]  tgt,
        input logic [RPOW_W-1:0] f,
        input logic              nb
    );
        logic signed [COL_W:0]    diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W-1:0] q;
        logic [COL_W:0]           res;
        diff = $signed({1'b0, v}) - $signed({1'b0, tgt});
        prod = $signed({1'b0, f}) * diff;
        if (prod[PROD_W-1])
            adj = prod + (nb ? RND_NB : RND_WIN);
        else
            adj = prod;
        q = nb ? (adj >>> (ALPHABIASSHIFT + RADBIASSHIFT)) : (adj >>> ALPHABIASSHIFT);
        res = {1'b0, v} - q[COL_W:0];
        return res[COL_W-1:0];
    endfunction

endpackage

>>> src/sptr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sptr_pkg for operand widths.
`timescale 1ns / 1ps
module sptr_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sptr_pkg::DIV_NUM_W-1:0] num,
    input  logic [sptr_pkg::DIV_DEN_W-1:0] den,
    output logic                           done,
    output logic [sptr_pkg::DIV_NUM_W-1:0] quot
);
    import sptr_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // Operand load on start, else one restoring step while busy
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> src/sptr_dp.sv
// Datapath: neuron memories, scan and update arithmetic, radius table,
// decay registers, configuration and output register. Uses sptr_pkg, sptr_div.
`timescale 1ns / 1ps
module sptr_dp #(
    parameter int NET_ENTRIES = 256,
    parameter int INIT_RADIUS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  sptr_pkg::cmd_t cmd,
    output sptr_pkg::sts_t sts,
    input  logic [31:0]    s_tdata,
    input  logic           s_tuser,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [0:0]     cfg_index,
    input  logic [23:0]    cfg_data,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata
);
    import sptr_pkg::*;

    localparam int IDX_W      = $clog2(NET_ENTRIES);
    localparam int AW         = 10;
    localparam int CLR_STEP_Q = 4096 / NET_ENTRIES;
    localparam int CLR_STEP_R = 4096 % NET_ENTRIES;
    localparam int FREQ_INIT  = 65536 / NET_ENTRIES;
    localparam logic [IDX_W:0] NET_R = (IDX_W + 1)'(NET_ENTRIES);
    localparam logic [AW-1:0]  NET_A = AW'(NET_ENTRIES);

    // Request registers
    logic [7:0]       red_reg, green_reg, blue_reg, req_index_reg;
    logic             req_read_reg;

    // Sequencing registers
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] wr_addr_reg;
    logic [COL_W-1:0] clr_q_reg;
    logic [IDX_W:0]   clr_r_reg;
    logic             scan_pend_reg;
    logic [RAD_W-1:0] m_reg;
    logic [4:0]       k_reg;

    // Training state
    logic [DIST_W-1:0]      bestd_reg;
    logic signed [BD_W-1:0] bestbd_reg;
    logic [IDX_W-1:0]       best_reg, bestb_reg;
    logic [LR_W-1:0]        lr_reg;
    logic [RADS_W-1:0]      radius_reg;
    logic [SAMP_W-1:0]      samp_reg;
    logic [7:0]             alpha_div_reg;
    logic [SAMP_W-1:0]      decay_int_reg;
    logic [RPOW_W-1:0]      rpow_reg [RPOW_DEPTH];

    // Memories and registered read data
    logic [3*COL_W-1:0] col_mem  [NET_ENTRIES];
    logic [BIAS_W-1:0]  bias_mem [NET_ENTRIES];
    logic [FREQ_W-1:0]  freq_mem [NET_ENTRIES];
    logic [3*COL_W-1:0] col_rd_reg;
    logic [BIAS_W-1:0]  bias_rd_reg;
    logic [FREQ_W-1:0]  freq_rd_reg;

    // Output register
    logic        out_vld_reg;
    logic [31:0] out_data_reg;

    // Combinational signals
    logic [IDX_W-1:0]       rd_addr;
    logic [AW-1:0]          up_sum, dn_diff;
    logic [COL_W-1:0]       rs, gs, bs;
    logic [COL_W-1:0]       nr, ng, nb;
    logic [DIST_W-1:0]      dist_sum;
    logic signed [BD_W-1:0] bias_sh, bd;
    logic                   first;
    logic [FREQ_W-1:0]      bf;
    logic [IDX_W:0]         clr_sum;
    logic [RAD_W-1:0]       rad_raw, cur_rad;
    logic [DIV_DEN_W-1:0]   rr;
    logic [9:0]             kk;
    logic [DIV_NUM_W-1:0]   fill_num;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0]   div_den;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quot;
    logic [LR_W+8:0]        fill_prod;
    logic [2*RADS_W-1:0]    rad_prod;
    logic [RADS_W-1:0]      rad_dec;
    logic [RPOW_W-1:0]      factor;
    logic [3*COL_W-1:0]     moved;
    logic [7:0]             alpha_eff;
    logic [SAMP_W-1:0]      int_eff, samp_next;
    logic                   col_we, bf_we;
    logic [IDX_W-1:0]       waddr;
    logic [3*COL_W-1:0]     col_wdata;
    logic [BIAS_W-1:0]      bias_wdata;
    logic [FREQ_W-1:0]      freq_wdata;
    logic                   in_range;
    logic [31:0]            res_data;

    // Neighbour addresses
    assign up_sum  = AW'(bestb_reg) + AW'(m_reg);
    assign dn_diff = AW'(bestb_reg) - AW'(m_reg);

    // Memory read address
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_IDX:   rd_addr = idx_reg;
            ADDR_REQ:   rd_addr = req_index_reg[IDX_W-1:0];
            ADDR_BEST:  rd_addr = best_reg;
            ADDR_BESTB: rd_addr = bestb_reg;
            ADDR_UP:    rd_addr = up_sum[IDX_W-1:0];
            ADDR_DN:    rd_addr = dn_diff[IDX_W-1:0];
            default:    rd_addr = idx_reg;
        endcase
    end

    // Distance and biased distance of the entry read last cycle
    assign rs = {red_reg,   4'b0};
    assign gs = {green_reg, 4'b0};
    assign bs = {blue_reg,  4'b0};
    assign nr = col_rd_reg[COL_W-1:0];
    assign ng = col_rd_reg[2*COL_W-1:COL_W];
    assign nb = col_rd_reg[3*COL_W-1:2*COL_W];

    always_comb
    begin
        dist_sum = DIST_W'(nr >= rs ? nr - rs : rs - nr)
                 + DIST_W'(ng >= gs ? ng - gs : gs - ng)
                 + DIST_W'(nb >= bs ? nb - bs : bs - nb);
        bias_sh = BD_W'($signed(bias_rd_reg) >>> (INTBIASSHIFT - NETBIASSHIFT));
        bd      = $signed(BD_W'(dist_sum)) - bias_sh;
        first   = (wr_addr_reg == '0);
        bf      = freq_rd_reg >> BETASHIFT;
    end

    // Radius and table fill operands
    always_comb
    begin
        rad_raw = radius_reg[RADS_W-1:RADIUSBIASSHIFT];
        if (rad_raw <= RAD_W'(1))
            cur_rad = '0;
        else if (rad_raw > RAD_W'(RPOW_DEPTH))
            cur_rad = RAD_W'(RPOW_DEPTH);
        else
            cur_rad = rad_raw;
        rr       = DIV_DEN_W'(cur_rad * cur_rad);
        kk       = 10'(k_reg * k_reg);
        fill_num = {DIV_DEN_W'(rr - DIV_DEN_W'(kk)), 8'b0};
        fill_prod = lr_reg * div_quot[8:0];
    end

    // Radius decay step by reciprocal multiplication
    assign rad_prod = radius_reg * RAD_RECIP;
    assign rad_dec  = RADS_W'(rad_prod >> RAD_RECIP_SH);

    // Shared divider operands
    always_comb
    begin
        alpha_eff = (alpha_div_reg == '0) ? 8'd1 : alpha_div_reg;
        case (cmd.div_sel)
            DIV_LR:
            begin
                div_num = DIV_NUM_W'(lr_reg);
                div_den = DIV_DEN_W'(alpha_eff);
            end
            default:
            begin
                div_num = fill_num;
                div_den = rr;
            end
        endcase
    end

    sptr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Colour pull toward the sample
    assign factor = cmd.move_nb ? rpow_reg[m_reg[4:0]] : RPOW_W'(lr_reg);
    assign moved  = {pull_colour(nb, bs, factor, cmd.move_nb),
                     pull_colour(ng, gs, factor, cmd.move_nb),
                     pull_colour(nr, rs, factor, cmd.move_nb)};

    // Memory write port selection
    always_comb
    begin
        clr_sum    = clr_r_reg + (IDX_W + 1)'(CLR_STEP_R);
        col_we     = cmd.clr_step | cmd.move_wr;
        bf_we      = cmd.clr_step | scan_pend_reg | cmd.boost_wr;
        waddr      = cmd.clr_step ? idx_reg : wr_addr_reg;
        col_wdata  = cmd.clr_step ? {clr_q_reg, clr_q_reg, clr_q_reg} : moved;
        if (cmd.clr_step)
        begin
            bias_wdata = '0;
            freq_wdata = FREQ_W'(FREQ_INIT);
        end
        else if (cmd.boost_wr)
        begin
            bias_wdata = bias_rd_reg - BIAS_W'(1 << (INTBIASSHIFT + GAMMASHIFT - BETASHIFT));
            freq_wdata = freq_rd_reg + FREQ_W'((1 << INTBIASSHIFT) >> BETASHIFT);
        end
        else
        begin
            bias_wdata = bias_rd_reg + BIAS_W'({bf, 10'b0});
            freq_wdata = freq_rd_reg - bf;
        end
    end

    // Neuron memories
    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[waddr] <= col_wdata;
        if (cmd.mem_rd)
            col_rd_reg <= col_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (bf_we)
            bias_mem[waddr] <= bias_wdata;
        if (cmd.mem_rd)
            bias_rd_reg <= bias_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (bf_we)
            freq_mem[waddr] <= freq_wdata;
        if (cmd.mem_rd)
            freq_rd_reg <= freq_mem[rd_addr];
    end

    // Radius power table
    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
            rpow_reg[k_reg] <= fill_prod[RPOW_W-1:0];
    end

    // Request and best-match payload
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            red_reg       <= s_tdata[7:0];
            green_reg     <= s_tdata[15:8];
            blue_reg      <= s_tdata[23:16];
            req_index_reg <= s_tdata[31:24];
            req_read_reg  <= s_tuser;
        end
        if (cmd.mem_rd)
            wr_addr_reg <= rd_addr;
        if (scan_pend_reg)
        begin
            if (first || dist_sum < bestd_reg)
            begin
                bestd_reg <= dist_sum;
                best_reg  <= wr_addr_reg;
            end
            if (first || bd < bestbd_reg)
            begin
                bestbd_reg <= bd;
                bestb_reg  <= wr_addr_reg;
            end
        end
    end

    // Decay arithmetic
    assign int_eff   = (decay_int_reg == '0) ? SAMP_W'(1) : decay_int_reg;
    assign samp_next = samp_reg + 1'b1;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            clr_q_reg     <= '0;
            clr_r_reg     <= '0;
            scan_pend_reg <= 1'b0;
            m_reg         <= '0;
            k_reg         <= '0;
            lr_reg        <= LR_W'(1 << ALPHABIASSHIFT);
            radius_reg    <= RADS_W'(INIT_RADIUS << RADIUSBIASSHIFT);
            samp_reg      <= '0;
            alpha_div_reg <= 8'd30;
            decay_int_reg <= SAMP_W'(1);
        end
        else
        begin
            scan_pend_reg <= cmd.scan_rd;
            if (cmd.idx_clear)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.clr_step)
            begin
                if (clr_sum >= NET_R)
                begin
                    clr_r_reg <= clr_sum - NET_R;
                    clr_q_reg <= clr_q_reg + COL_W'(CLR_STEP_Q + 1);
                end
                else
                begin
                    clr_r_reg <= clr_sum;
                    clr_q_reg <= clr_q_reg + COL_W'(CLR_STEP_Q);
                end
            end
            if (cmd.m_clear)
                m_reg <= RAD_W'(1);
            else if (cmd.m_inc)
                m_reg <= m_reg + 1'b1;
            if (cmd.k_clear)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + 1'b1;
            if (cmd.lr_upd)
                lr_reg <= lr_reg - div_quot[LR_W-1:0];
            if (cmd.rad_upd)
                radius_reg <= radius_reg - rad_dec;
            if (cmd.samp_upd)
                samp_reg <= (samp_next >= int_eff) ? '0 : samp_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ALPHA_DIV: alpha_div_reg <= cfg_data[7:0];
                    CFG_DECAY_INT: decay_int_reg <= cfg_data;
                    default:       alpha_div_reg <= alpha_div_reg;
                endcase
            end
        end
    end

    // Result assembly
    always_comb
    begin
        in_range = ({1'b0, req_index_reg} < AW'(NET_A));
        if (req_read_reg)
        begin
            if (in_range)
                res_data = {col_rd_reg[3*COL_W-1:3*COL_W-8], col_rd_reg[2*COL_W-1:2*COL_W-8],
                            col_rd_reg[COL_W-1:COL_W-8], req_index_reg};
            else
                res_data = {24'b0, req_index_reg};
        end
        else
        begin
            res_data = {24'b0, 8'(bestb_reg)};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.res_load)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
            out_data_reg <= res_data;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Status to the controller
    always_comb
    begin
        sts.idx_last  = (idx_reg == IDX_W'(NET_ENTRIES - 1));
        sts.div_done  = div_done;
        sts.rad_zero  = (cur_rad == '0);
        sts.k_last    = ({1'b0, k_reg} == cur_rad - 1'b1);
        sts.nb_end    = (m_reg >= cur_rad);
        sts.up_ok     = (up_sum < NET_A);
        sts.dn_ok     = (AW'(m_reg) <= AW'(bestb_reg));
        sts.decay_due = (samp_next >= int_eff);
        sts.out_free  = !out_vld_reg || m_tready;
    end

endmodule

>>> src/sptr_ctrl.sv
// Controller state machine: sequences clearing, read requests, scan, updates,
// neighbour moves, decay, table fill and result output. Uses sptr_pkg types.
`timescale 1ns / 1ps
module sptr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tuser,
    output logic           s_tready,
    input  sptr_pkg::sts_t sts,
    output sptr_pkg::cmd_t cmd
);
    import sptr_pkg::*;

    state_t state_reg, state_next;
    logic   boot_reg, boot_next;
    state_t fill_exit;

    assign fill_exit = boot_reg ? ST_IDLE : ST_OUT;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        boot_next  = boot_reg;
        case (state_reg)
            ST_CLEAR:
                if (sts.idx_last)
                    state_next = ST_FILL_DIV;
            ST_FILL_DIV:
                if (sts.rad_zero)
                begin
                    state_next = fill_exit;
                    boot_next  = 1'b0;
                end
                else
                    state_next = ST_FILL_WAIT;
            ST_FILL_WAIT:
                if (sts.div_done)
                begin
                    if (sts.k_last)
                    begin
                        state_next = fill_exit;
                        boot_next  = 1'b0;
                    end
                    else
                        state_next = ST_FILL_DIV;
                end
            ST_IDLE:
                if (s_tvalid)
                    state_next = s_tuser ? ST_RD : ST_SCAN;
            ST_RD:
                state_next = ST_RD_OUT;
            ST_RD_OUT:
                if (sts.out_free)
                    state_next = ST_IDLE;
            ST_SCAN:
                if (sts.idx_last)
                    state_next = ST_SCAN_END;
            ST_SCAN_END:
                state_next = ST_BOOST_RD;
            ST_BOOST_RD:
                state_next = ST_BOOST_WR;
            ST_BOOST_WR:
                state_next = ST_WIN_RD;
            ST_WIN_RD:
                state_next = ST_WIN_WR;
            ST_WIN_WR:
                state_next = sts.rad_zero ? ST_DECAY : ST_NB_UP;
            ST_NB_UP:
                if (sts.nb_end)
                    state_next = ST_DECAY;
                else if (sts.up_ok)
                    state_next = ST_NB_UPW;
                else
                    state_next = ST_NB_DN;
            ST_NB_UPW:
                state_next = ST_NB_DN;
            ST_NB_DN:
                state_next = sts.dn_ok ? ST_NB_DNW : ST_NB_UP;
            ST_NB_DNW:
                state_next = ST_NB_UP;
            ST_DECAY:
                state_next = sts.decay_due ? ST_LR_WAIT : ST_OUT;
            ST_LR_WAIT:
                if (sts.div_done)
                    state_next = ST_RAD_UPD;
            ST_RAD_UPD:
                state_next = ST_FILL_DIV;
            ST_OUT:
                if (sts.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.addr_sel = ADDR_IDX;
        cmd.div_sel  = DIV_FILL;
        s_tready     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                cmd.idx_inc  = 1'b1;
                cmd.k_clear  = sts.idx_last;
            end
            ST_FILL_DIV:
                cmd.div_start = !sts.rad_zero;
            ST_FILL_WAIT:
            begin
                cmd.fill_wr = sts.div_done;
                cmd.k_inc   = sts.div_done && !sts.k_last;
            end
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.req_load  = s_tvalid;
                cmd.idx_clear = s_tvalid;
            end
            ST_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_REQ;
            end
            ST_RD_OUT:
                cmd.res_load = sts.out_free;
            ST_SCAN:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.scan_rd = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            ST_SCAN_END:
                cmd.mem_rd = 1'b0;
            ST_BOOST_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_BEST;
            end
            ST_BOOST_WR:
                cmd.boost_wr = 1'b1;
            ST_WIN_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_BESTB;
            end
            ST_WIN_WR:
            begin
                cmd.move_wr = 1'b1;
                cmd.m_clear = 1'b1;
            end
            ST_NB_UP:
            begin
                cmd.mem_rd   = !sts.nb_end && sts.up_ok;
                cmd.addr_sel = ADDR_UP;
            end
            ST_NB_UPW:
            begin
                cmd.move_wr = 1'b1;
                cmd.move_nb = 1'b1;
            end
            ST_NB_DN:
            begin
                cmd.mem_rd   = sts.dn_ok;
                cmd.addr_sel = ADDR_DN;
                cmd.m_inc    = !sts.dn_ok;
            end
            ST_NB_DNW:
            begin
                cmd.move_wr = 1'b1;
                cmd.move_nb = 1'b1;
                cmd.m_inc   = 1'b1;
            end
            ST_DECAY:
            begin
                cmd.samp_upd  = 1'b1;
                cmd.div_start = sts.decay_due;
                cmd.div_sel   = DIV_LR;
            end
            ST_LR_WAIT:
            begin
                cmd.div_sel = DIV_LR;
                cmd.lr_upd  = sts.div_done;
            end
            ST_RAD_UPD:
            begin
                cmd.rad_upd = 1'b1;
                cmd.k_clear = 1'b1;
            end
            ST_OUT:
                cmd.res_load = sts.out_free;
            default:
                cmd.mem_rd = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            boot_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
        end
    end

endmodule

>>> src/som_palette_trainer.sv
// A read item reads its entry and loads it into the output register once free.
// A train item runs the one-entry-per-cycle neuron scan, the winner updates and the
// neighbour moves; a decay step adds a serial learning-rate divide and a radius table
// refill of one divide per entry. One item is worked at a time; the next is taken
// while a result waits. After reset a clearing pass over every entry and a table fill
// run before the first item; configuration is taken always.
`timescale 1ns / 1ps
module som_palette_trainer #(
    parameter int NET_ENTRIES = 256,
    parameter int INIT_RADIUS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red, green, blue, entry_index
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // winner_index, red_out, green_out, blue_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import sptr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    sptr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sptr_dp #(
        .NET_ENTRIES (NET_ENTRIES),
        .INIT_RADIUS (INIT_RADIUS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> src/sptr_checker.sv
// Port-level checks for som_palette_trainer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sptr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        cfg_ready
);
    // A stalled result stays offered
    `SPTR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    // A stalled result keeps its data
    `SPTR_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    // One item at a time: input closes after each transfer
    `SPTR_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready)
    // Configuration port never stalls
    `SPTR_ASSERT_IMP(a_cfg_open, 1'b1, cfg_ready)
endmodule

bind som_palette_trainer sptr_checker u_sptr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
